// File: hdl/client_session_counter_table_top_macros.svh
// assertion helpers used by the bound checker csct_checker
`ifndef CLIENT_SESSION_COUNTER_TABLE_TOP_MACROS_SVH
`define CLIENT_SESSION_COUNTER_TABLE_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CSCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("csct check failed");

// next-cycle implication, disabled while reset is asserted
`define CSCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("csct check failed");

`endif

// File: hdl/csct_pkg.sv
`timescale 1ns / 1ps

package csct_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 64;

	localparam int unsigned KEY_W   = 48;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned MODE_W  = 8;
	localparam int unsigned STAT_W  = 3;

	// message type bytes
	localparam logic [MODE_W-1:0] MODE_COUNT = 8'd77;
	localparam logic [MODE_W-1:0] MODE_CLOSE = 8'd67;

	// result status codes
	localparam logic [STAT_W-1:0] STATUS_COUNTED = 3'd0;
	localparam logic [STAT_W-1:0] STATUS_CLOSED  = 3'd1;
	localparam logic [STAT_W-1:0] STATUS_UNKNOWN = 3'd2;
	localparam logic [STAT_W-1:0] STATUS_FULL    = 3'd3;
	localparam logic [STAT_W-1:0] STATUS_IGNORED = 3'd4;

	// word travelling down the chain
	typedef struct packed {
		logic               vld;
		logic               is_m;
		logic               is_c;
		logic               done;
		logic               shift;
		logic [KEY_W-1:0]   key;
		logic [COUNT_W-1:0] cnt;
	} item_t;

	// one table entry held by a cell
	typedef struct packed {
		logic               vld;
		logic [KEY_W-1:0]   key;
		logic [COUNT_W-1:0] cnt;
	} entry_t;

endpackage

// File: hdl/csct_cell.sv
`timescale 1ns / 1ps

module csct_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  csct_pkg::item_t  item_in,
	output csct_pkg::item_t  item_out,
	input  csct_pkg::entry_t right_entry,
	output csct_pkg::entry_t entry_out
);
	import csct_pkg::*;

	item_t  item_q;
	item_t  nxt_item;
	entry_t entry_q;
	entry_t nxt_entry;
	logic   key_hit;

	always_comb begin
		nxt_item  = item_in;
		nxt_entry = entry_q;
		key_hit   = entry_q.vld && (entry_q.key == item_in.key);
		if (item_in.vld) begin
			if (item_in.shift) begin
				// entry moves one cell to the left this cycle
				nxt_entry.vld = 1'b0;
			end else if (!item_in.done && item_in.is_m) begin
				if (key_hit) begin
					nxt_entry.cnt = entry_q.cnt + 32'd1;
					nxt_item.cnt  = entry_q.cnt + 32'd1;
					nxt_item.done = 1'b1;
				end else if (!entry_q.vld) begin
					// first empty cell: key is nowhere else, table is packed
					nxt_entry.vld = 1'b1;
					nxt_entry.key = item_in.key;
					nxt_entry.cnt = 32'd1;
					nxt_item.cnt  = 32'd1;
					nxt_item.done = 1'b1;
				end
			end else if (!item_in.done && item_in.is_c && key_hit) begin
				nxt_entry.vld  = 1'b0;
				nxt_item.done  = 1'b1;
				nxt_item.shift = 1'b1;
			end
		end
		// close hole behind the word: take the right neighbour's entry
		if (item_q.vld && item_q.shift) begin
			nxt_entry = right_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q  <= '0;
			entry_q <= '0;
		end else begin
			item_q  <= nxt_item;
			entry_q <= nxt_entry;
		end
	end

	assign item_out  = item_q;
	assign entry_out = entry_q;

endmodule

// File: hdl/client_session_counter_table_top.sv
`timescale 1ns / 1ps
// per-client message counter table, keyed by {client_address, client_port}
// input channel: in_valid / in_stall carry one word (mode, address, port)
// output channel: out_valid / out_stall carry one word (status, count)
// every input word gives exactly one output word
// the table is a row of TABLE_ENTRIES cells; the word walks one cell per cycle
// valid entries are kept packed at the low end, so a new key takes the first empty
// cell and a close shifts the later entries one cell left as the word passes
// the word passes through each cell's register in turn; the result register then loads
// from the word leaving the last cell and out_valid rises; only one word is in flight,
// as in_stall is high from accept until the result is taken
// while out_stall is high the result word holds and no new word is taken
// reset clears every cell (valid flag, key, count and word register) and the control
// state; the status and count output registers are not reset
module client_session_counter_table_top #(
	parameter int unsigned TABLE_ENTRIES = csct_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [csct_pkg::MODE_W-1:0]    mode,
	input  logic [31:0]                    client_address,
	input  logic [15:0]                    client_port,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [csct_pkg::STAT_W-1:0]    status,
	output logic [csct_pkg::COUNT_W-1:0]   count
);
	import csct_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t state_q;
	logic   accept;
	item_t  head;
	item_t  tail;
	logic [STAT_W-1:0]  status_q;
	logic [COUNT_W-1:0] count_q;
	logic [STAT_W-1:0]  nxt_status;

	item_t  chain_item  [TABLE_ENTRIES+1];
	entry_t chain_entry [TABLE_ENTRIES+1];

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// word entering the first cell
	always_comb begin
		head       = '0;
		head.vld   = accept;
		head.is_m  = (mode == MODE_COUNT);
		head.is_c  = (mode == MODE_CLOSE);
		head.key   = {client_address, client_port};
	end

	assign chain_item[0]              = head;
	assign chain_entry[TABLE_ENTRIES] = '0;   // beyond the last cell: always empty

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		csct_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.item_in     (chain_item[i]),
			.item_out    (chain_item[i+1]),
			.right_entry (chain_entry[i+1]),
			.entry_out   (chain_entry[i])
		);
	end

	assign tail = chain_item[TABLE_ENTRIES];

	// result code from the word leaving the last cell
	always_comb begin
		if (tail.is_m) begin
			nxt_status = tail.done ? STATUS_COUNTED : STATUS_FULL;
		end else if (tail.is_c) begin
			nxt_status = tail.done ? STATUS_CLOSED : STATUS_UNKNOWN;
		end else begin
			nxt_status = STATUS_IGNORED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (tail.vld) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output word register; count is zero unless counted
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && tail.vld) begin
			status_q <= nxt_status;
			count_q  <= (tail.is_m && tail.done) ? tail.cnt : '0;
		end
	end

	assign out_valid = (state_q == ST_OUT);
	assign status    = status_q;
	assign count     = count_q;

endmodule

// File: hdl/csct_checker.sv
`timescale 1ns / 1ps
`include "client_session_counter_table_top_macros.svh"

module csct_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic [csct_pkg::MODE_W-1:0]  mode,
	input logic [31:0]                  client_address,
	input logic [15:0]                  client_port,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [csct_pkg::STAT_W-1:0]  status,
	input logic [csct_pkg::COUNT_W-1:0] count
);
	import csct_pkg::*;

	// a stalled result word holds
	`CSCT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(count))

	// only defined status codes leave the block
	`CSCT_ASSERT_NOW(a_status_range, clk, arst_n, out_valid, status <= STATUS_IGNORED)

	// count is zero for everything but a counted word
	`CSCT_ASSERT_NOW(a_count_zero, clk, arst_n, out_valid && (status != STATUS_COUNTED), count == '0)

	// one word in flight: after an accept the input is stalled
	`CSCT_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && !in_stall, in_stall)

endmodule

bind client_session_counter_table_top csct_checker u_csct_checker (.*);

// File: sim/client_session_counter_table_checker.sv
`timescale 1ns / 1ps

module client_session_counter_table_checker #(
	parameter int unsigned DEPTH = csct_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [csct_pkg::MODE_W-1:0]  mode,
	input  logic [31:0]                  client_address,
	input  logic [15:0]                  client_port,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [csct_pkg::STAT_W-1:0]  status,
	input  logic [csct_pkg::COUNT_W-1:0] count,
	output int                           failures,
	output int                           pending
);
	import csct_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0]  code;
		logic [COUNT_W-1:0] tally;
	} reply_t;

	// shadow of the counter table
	logic [KEY_W-1:0]   keys    [DEPTH];
	logic [COUNT_W-1:0] tallies [DEPTH];
	logic               held    [DEPTH];

	reply_t replies_due[$];
	int     errors;

	function automatic int find_key(input logic [KEY_W-1:0] key);
		int slot;
		slot = -1;
		for (int i = DEPTH - 1; i >= 0; i--)
			if (held[i] && keys[i] == key)
				slot = i;
		return slot;
	endfunction

	// applies one message to the shadow table, counts wrap at 32 bits
	function automatic reply_t tally_message(input logic [MODE_W-1:0] kind,
			input logic [31:0] addr, input logic [15:0] port);
		logic [KEY_W-1:0] key;
		int               slot;
		reply_t           r;
		key = {addr, port};
		r.code = STATUS_IGNORED;
		r.tally = '0;
		if (kind == MODE_CLOSE) begin
			slot = find_key(key);
			if (slot >= 0) begin
				held[slot] = 1'b0;
				r.code = STATUS_CLOSED;
			end else begin
				r.code = STATUS_UNKNOWN;
			end
		end else if (kind == MODE_COUNT) begin
			slot = find_key(key);
			if (slot < 0) begin
				// lowest free slot
				for (int i = DEPTH - 1; i >= 0; i--)
					if (!held[i])
						slot = i;
				if (slot >= 0) begin
					keys[slot] = key;
					tallies[slot] = '0;
					held[slot] = 1'b1;
				end
			end
			if (slot >= 0) begin
				tallies[slot] = tallies[slot] + COUNT_W'(1);
				r.code = STATUS_COUNTED;
				r.tally = tallies[slot];
			end else begin
				r.code = STATUS_FULL;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				held[i] = 1'b0;
			replies_due.delete();
			errors = 0;
			failures <= 0;
			pending <= 0;
		end else begin
			// results first, so a word taken on this edge is not matched early
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: expected none, actual status %0d count %0d",
						$time, status, count);
				end else begin
					want = replies_due.pop_front();
					if (status !== want.code) begin
						errors++;
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.code, status);
					end
					if (count !== want.tally) begin
						errors++;
						$display("%0t: count mismatch: expected %0d, actual %0d",
							$time, want.tally, count);
					end
				end
			end
			if (in_valid && !in_stall)
				replies_due.push_back(tally_message(mode, client_address, client_port));
			failures <= errors;
			pending <= replies_due.size();
		end
	end

endmodule

// File: sim/client_session_counter_table_top_tb.sv
`timescale 1ns / 1ps

module client_session_counter_table_top_tb;
	import csct_pkg::*;

	localparam int unsigned DEPTH       = TABLE_ENTRIES_DEF;
	localparam int          WORD_TARGET = 1400;
	localparam int          LONG_HOLD   = 400;
	localparam int          CYCLE_LIMIT = 1000000;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               in_valid       = 1'b0;
	logic               in_stall;
	logic [MODE_W-1:0]  mode           = '0;
	logic [31:0]        client_address = '0;
	logic [15:0]        client_port    = '0;
	logic               out_valid;
	logic               out_stall      = 1'b0;
	logic [STAT_W-1:0]  status;
	logic [COUNT_W-1:0] count;

	int failures;
	int pending;

	// idling knobs, changed by the stimulus between words
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// long hold-off requests, served by the receiver process
	int holds_asked  = 0;
	int holds_served = 0;
	int hold_left    = 0;

	int cycles     = 0;
	int words_sent = 0;

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	client_session_counter_table_top #(
		.TABLE_ENTRIES (DEPTH)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.client_address (client_address),
		.client_port    (client_port),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.count          (count)
	);

	client_session_counter_table_checker #(
		.DEPTH (DEPTH)
	) checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.client_address (client_address),
		.client_port    (client_port),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.count          (count),
		.failures       (failures),
		.pending        (pending)
	);

	// receiver: random stalls, or a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_served != holds_asked) begin
			out_stall <= 1'b1;
			hold_left <= LONG_HOLD;
			holds_served <= holds_served + 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// offers one word and holds it until the block takes it
	task automatic send_word(input logic [MODE_W-1:0] kind, input logic [KEY_W-1:0] key);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= kind;
		client_address <= key[KEY_W-1:16];
		client_port <= key[15:0];
		do @(posedge clk); while (in_stall);
		// ignored types do not count towards the target
		if (kind == MODE_COUNT || kind == MODE_CLOSE)
			words_sent++;
	endtask

	initial begin
		logic [KEY_W-1:0] pool[$];
		logic [KEY_W-1:0] retired[$];
		logic [KEY_W-1:0] strays[$];
		logic [KEY_W-1:0] key;
		int               episode;
		int               len;
		int               pick;
		int               pool_size;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, near-code type bytes, reopen after close
		send_word(8'h00, '0);
		send_word(8'hFF, '1);
		send_word(MODE_CLOSE, '0);              // close of unknown key
		send_word(MODE_COUNT, '0);              // new entry, count 1
		send_word(MODE_COUNT, '0);              // existing entry, count 2
		send_word(MODE_COUNT, '1);
		send_word(MODE_COUNT, {32'h0, 16'hFFFF});
		send_word(MODE_COUNT, {32'hFFFF_FFFF, 16'h0});
		send_word(MODE_COUNT - 8'd1, '0);
		send_word(MODE_COUNT + 8'd1, '0);
		send_word(MODE_CLOSE - 8'd1, '0);
		send_word(MODE_CLOSE + 8'd1, '0);
		send_word(MODE_COUNT, '1);
		send_word(MODE_CLOSE, '0);              // frees the lowest slot
		send_word(MODE_CLOSE, '0);              // now unknown
		send_word(MODE_COUNT, {32'h1, 16'h0});  // new key into the freed slot
		send_word(MODE_COUNT, '0);              // reopened key starts again at 1
		send_word(MODE_CLOSE, '1);
		send_word(MODE_CLOSE, {32'h0, 16'hFFFF});
		send_word(MODE_CLOSE, {32'hFFFF_FFFF, 16'h0});
		send_word(MODE_CLOSE, {32'h1, 16'h0});
		send_word(MODE_CLOSE, '0);              // table empty again

		// random episodes over a pool of client keys
		episode = 0;
		while (words_sent < WORD_TARGET) begin
			case (episode % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 77;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 77;
				end
				default: begin
					send_idle_pct = 9;
					recv_stall_pct = 9;
				end
			endcase

			// every third pool is larger than the table, so it fills and drops
			pool.delete();
			pool_size = (episode % 3 == 2) ? $urandom_range(DEPTH + 2, DEPTH + 26)
				: $urandom_range(4, DEPTH - 4);
			repeat (pool_size)
				pool.push_back({$urandom, 16'($urandom)});

			len = $urandom_range(80, 200);
			for (int n = 0; n < len; n++) begin
				// once, in episode 2: a long receiver hold-off keeps a result waiting and stalls the input
				if (episode == 2 && n == 20)
					holds_asked <= holds_asked + 1;
				pick = $urandom_range(99);
				key = pool[$urandom_range(pool.size() - 1)];
				if (pick < 6) begin
					// noise on the type byte
					send_word(8'($urandom), key);
				end else if (pick < 9) begin
					// near miss: one key bit flipped
					key = key ^ ({{(KEY_W-1){1'b0}}, 1'b1} << $urandom_range(KEY_W - 1));
					if (pick == 8) begin
						strays.push_back(key);
						send_word(MODE_COUNT, key);
					end else begin
						send_word(MODE_CLOSE, key);
					end
				end else if (pick < 11) begin
					key = {$urandom, 16'($urandom)};
					strays.push_back(key);
					send_word(MODE_COUNT, key);
				end else if (pick < 33) begin
					send_word(MODE_CLOSE, key);
				end else begin
					send_word(MODE_COUNT, key);
				end
			end

			// on odd episodes close everything opened so far, else keep it resident
			if (episode % 2 == 1) begin
				foreach (pool[i])
					send_word(MODE_CLOSE, pool[i]);
				foreach (retired[i])
					send_word(MODE_CLOSE, retired[i]);
				foreach (strays[i])
					send_word(MODE_CLOSE, strays[i]);
				retired.delete();
				strays.delete();
			end else begin
				foreach (pool[i])
					retired.push_back(pool[i]);
			end
			episode++;
		end

		// drain: receiver stops stalling, wait for the last result, then settle
		in_valid <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		do @(posedge clk); while (pending != 0);
		repeat (2 * DEPTH) @(posedge clk);

		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
